@@ rtl/tcoi_pkg.sv @@
`timescale 1ns / 1ps

package tcoi_pkg;

   // Fixed field widths of the request and response beats.
   localparam int DATA_W      = 8;
   localparam int ROW_W       = 24;
   localparam int COL_OUT_W   = 6;
   localparam int OFS_OUT_W   = 24;
   localparam int LEN_OUT_W   = 24;
   localparam int COUNT_OUT_W = 7;

   // Separator characters.
   localparam logic [DATA_W-1:0] CH_TAB = 8'h09;
   localparam logic [DATA_W-1:0] CH_CR  = 8'h0d;
   localparam logic [DATA_W-1:0] CH_LF  = 8'h0a;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // a request beat is taken this cycle
      logic advance;  // the current record is taken and a padding record follows
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emits;    // the byte on the request channel produces records
      logic last;     // the record in the output register is the last of its run
   } dp_status_type;

endpackage

@@ rtl/tcoi_req_if.sv @@
`timescale 1ns / 1ps

interface tcoi_req_if import tcoi_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

@@ rtl/tcoi_rsp_if.sv @@
`timescale 1ns / 1ps

interface tcoi_rsp_if import tcoi_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ROW_W-1:0]       row_index;
   logic [COL_OUT_W-1:0]   column_index;
   logic [OFS_OUT_W-1:0]   cell_offset;
   logic [LEN_OUT_W-1:0]   cell_length;
   logic                   last_of_run;
   logic [COUNT_OUT_W-1:0] column_count;
   logic                   width_overflow;

   modport source (output valid, output row_index, output column_index, output cell_offset,
                   output cell_length, output last_of_run, output column_count,
                   output width_overflow, input ready);
   modport sink   (input valid, input row_index, input column_index, input cell_offset,
                   input cell_length, input last_of_run, input column_count,
                   input width_overflow, output ready);
endinterface

@@ rtl/tcoi_ctrl.sv @@
`timescale 1ns / 1ps

module tcoi_ctrl import tcoi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.accept  = 1'b0;
      cmd.advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && status.emits) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/tcoi_datapath.sv @@
`timescale 1ns / 1ps

module tcoi_datapath import tcoi_pkg::*; #(
   parameter int MAX_COLUMNS = 64,
   parameter int OFFSET_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  logic [DATA_W-1:0]      data_byte,
   input  logic                   end_of_buffer,
   output logic [ROW_W-1:0]       row_index,
   output logic [COL_OUT_W-1:0]   column_index,
   output logic [OFS_OUT_W-1:0]   cell_offset,
   output logic [LEN_OUT_W-1:0]   cell_length,
   output logic                   last_of_run,
   output logic [COUNT_OUT_W-1:0] column_count,
   output logic                   width_overflow
);

   localparam int OW = OFFSET_BITS;
   localparam int CW = $clog2(MAX_COLUMNS);
   localparam int WW = $clog2(MAX_COLUMNS + 1);

   // Parse state.
   logic [OW-1:0]    pos_ff, pos_in;
   logic [OW-1:0]    start_ff, start_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WW-1:0]    width_ff, width_in;
   logic             first_ff, first_in;
   logic             after_cr_ff, after_cr_in;
   logic             ovf_ff, ovf_in;

   // Record being offered and the padding run that follows it.
   logic [ROW_W-1:0]       row_out_ff, row_out_in;
   logic [COL_OUT_W-1:0]   col_out_ff, col_out_in;
   logic [OFS_OUT_W-1:0]   off_out_ff, off_out_in;
   logic [LEN_OUT_W-1:0]   len_out_ff, len_out_in;
   logic [COUNT_OUT_W-1:0] count_out_ff, count_out_in;
   logic                   ovf_out_ff, ovf_out_in;
   logic [WW-1:0]          pad_col_ff, pad_col_in;
   logic [WW-1:0]          pad_limit_ff, pad_limit_in;
   logic [OW-1:0]          pad_off_ff, pad_off_in;

   logic [OW-1:0] p, np;
   logic [OW-1:0] len_closed, len_open;
   logic [WW-1:0] col_inc;
   logic          is_tab, is_eol, skip_lf, wrap;

   assign p       = pos_ff;
   assign np      = pos_ff + OW'(1);
   // Cell lengths wrap at the offset width before they reach the record.
   assign len_closed = p - start_ff;
   assign len_open   = np - start_ff;
   assign col_inc = WW'(col_ff) + WW'(1);
   assign is_tab  = (data_byte == CH_TAB);
   assign is_eol  = (data_byte == CH_CR) || (data_byte == CH_LF);
   assign skip_lf = after_cr_ff && (data_byte == CH_LF);

   assign status.emits = !skip_lf && (is_tab || is_eol || end_of_buffer);
   assign status.last  = (pad_col_ff >= pad_limit_ff);

   always_comb begin
      pos_in       = pos_ff;
      start_in     = start_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      width_in     = width_ff;
      first_in     = first_ff;
      after_cr_in  = after_cr_ff;
      ovf_in       = ovf_ff;
      row_out_in   = row_out_ff;
      col_out_in   = col_out_ff;
      off_out_in   = off_out_ff;
      len_out_in   = len_out_ff;
      count_out_in = count_out_ff;
      ovf_out_in   = ovf_out_ff;
      pad_col_in   = pad_col_ff;
      pad_limit_in = pad_limit_ff;
      pad_off_in   = pad_off_ff;
      wrap         = 1'b0;

      if (cmd.accept) begin
         after_cr_in = 1'b0;
         row_out_in  = row_ff;
         col_out_in  = COL_OUT_W'(col_ff);
         off_out_in  = OFS_OUT_W'(start_ff);
         len_out_in  = LEN_OUT_W'(len_closed);
         pad_off_in  = np;
         priority if (skip_lf) begin
            start_in = np;
         end else if (is_tab) begin
            if (first_ff) begin
               if (col_inc < WW'(MAX_COLUMNS)) begin
                  width_in = col_inc + WW'(1);
               end else begin
                  ovf_in = 1'b1;
                  wrap   = 1'b1;
               end
            end else begin
               wrap = (col_inc >= width_ff);
            end
            start_in     = np;
            pad_limit_in = width_in;
            if (wrap) begin
               row_in     = row_ff + ROW_W'(1);
               col_in     = '0;
               pad_col_in = width_in;
            end else begin
               col_in     = CW'(col_inc);
               pad_col_in = end_of_buffer ? col_inc : width_in;
            end
         end else if (is_eol) begin
            pad_col_in   = col_inc;
            pad_limit_in = width_ff;
            row_in       = row_ff + ROW_W'(1);
            col_in       = '0;
            first_in     = 1'b0;
            after_cr_in  = (data_byte == CH_CR);
            start_in     = np;
         end else begin
            // Any other byte: if it is the last byte of the buffer, the cell includes it.
            len_out_in   = LEN_OUT_W'(len_open);
            pad_col_in   = col_inc;
            pad_limit_in = width_ff;
         end
         count_out_in = COUNT_OUT_W'(width_in);
         ovf_out_in   = ovf_in;
         pos_in       = np;
         if (end_of_buffer) begin
            pos_in      = '0;
            start_in    = '0;
            col_in      = '0;
            row_in      = '0;
            width_in    = WW'(1);
            first_in    = 1'b1;
            after_cr_in = 1'b0;
            ovf_in      = 1'b0;
         end
      end else if (cmd.advance) begin
         col_out_in = COL_OUT_W'(pad_col_ff);
         off_out_in = OFS_OUT_W'(pad_off_ff);
         len_out_in = '0;
         pad_col_in = pad_col_ff + WW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         start_ff    <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         width_ff    <= WW'(1);
         first_ff    <= 1'b1;
         after_cr_ff <= 1'b0;
         ovf_ff      <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         start_ff    <= start_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         width_ff    <= width_in;
         first_ff    <= first_in;
         after_cr_ff <= after_cr_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      row_out_ff   <= row_out_in;
      col_out_ff   <= col_out_in;
      off_out_ff   <= off_out_in;
      len_out_ff   <= len_out_in;
      count_out_ff <= count_out_in;
      ovf_out_ff   <= ovf_out_in;
      pad_col_ff   <= pad_col_in;
      pad_limit_ff <= pad_limit_in;
      pad_off_ff   <= pad_off_in;
   end

   assign row_index      = row_out_ff;
   assign column_index   = col_out_ff;
   assign cell_offset    = off_out_ff;
   assign cell_length    = len_out_ff;
   assign last_of_run    = status.last;
   assign column_count   = count_out_ff;
   assign width_overflow = ovf_out_ff;

   // The open column always lies inside the learned width.
   a_col_in_width: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < width_ff)
      else $error("open column outside learned width");

   // The learned width never leaves its legal range.
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      (width_ff >= WW'(1)) && (width_ff <= WW'(MAX_COLUMNS)))
      else $error("learned width out of range");

   // The last byte of a buffer leaves the parser ready for a fresh buffer.
   a_eob_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && end_of_buffer) |=>
         (pos_ff == '0) && (row_ff == '0) && (col_ff == '0) && first_ff && !ovf_ff)
      else $error("parser state not restarted after end of buffer");

endmodule

@@ rtl/tsv_cell_offset_indexer_core.sv @@
// A byte that closes a cell shows its first record in the cycle after its beat is taken.
// A byte that emits nothing leaves the controller ready for the next beat. A byte that
// emits records holds off further bytes until its last record is taken: the controller offers
// one record at a time from the output register and takes no byte while a run is pending.
// Reset: synchronous, active high; parsing restarts at row 0, column 0, offset 0.
`timescale 1ns / 1ps

module tsv_cell_offset_indexer_core import tcoi_pkg::*; #(
   parameter int MAX_COLUMNS = 64,
   parameter int OFFSET_BITS = 24
) (
   input logic      clock,
   input logic      reset,
   tcoi_req_if.sink   req_chan,
   tcoi_rsp_if.source rsp_chan
);

   // The controller decides when a request beat is taken and when the record in the
   // output register moves on; the datapath holds the parse state and the record.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   tcoi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Every byte advances the byte position. Tabs, line ends and the last byte of the
   // buffer load a cell record; a short row then queues a run of empty padding cells
   // that all point at the byte after the terminator.
   tcoi_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .data_byte      (req_chan.data_byte),
      .end_of_buffer  (req_chan.end_of_buffer),
      .row_index      (rsp_chan.row_index),
      .column_index   (rsp_chan.column_index),
      .cell_offset    (rsp_chan.cell_offset),
      .cell_length    (rsp_chan.cell_length),
      .last_of_run    (rsp_chan.last_of_run),
      .column_count   (rsp_chan.column_count),
      .width_overflow (rsp_chan.width_overflow)
   );

endmodule
